>>> src/qf2h_pkg.sv
package qf2h_pkg;

	localparam int NDIGS = 29;
	localparam int SIG_W = 4 * NDIGS;

	localparam logic [14:0] EXP_ALL_ONES = 15'h7fff;
	localparam logic signed [15:0] EXP_BIAS = 16'sd16383;
	localparam logic signed [15:0] EXP_DENORM = -16'sd16382;
	localparam logic signed [15:0] EXP_SPECIAL = 16'sd16384;

	localparam logic [4:0] PREC_MAX = 5'd28;
	localparam logic [7:0] PREC_LIMIT = 8'd28;

	localparam logic [3:0] NIB_HALF = 4'h8;
	localparam logic [3:0] NIB_NINE = 4'h9;
	localparam logic [6:0] CHAR_ZERO = 7'h30;
	localparam logic [6:0] CHAR_UPPER_BASE = 7'h37;
	localparam logic [6:0] CHAR_LOWER_BASE = 7'h57;

	typedef struct packed {
		logic [SIG_W-1:0] sig;
		logic neg;
		logic nan;
		logic inf;
		logic upper;
		logic signed [15:0] exp;
		logic [4:0] dap;
	} desc_t;

	typedef struct packed {
		logic [SIG_W-1:0] sig;
		logic neg;
		logic nan;
		logic inf;
		logic upper;
		logic signed [15:0] exp;
		logic [4:0] prec;
		logic [4:0] dap;
		logic round_en;
		logic up;
	} front_t;

	function automatic logic [3:0] nibble_at(logic [SIG_W-1:0] sig, logic [4:0] idx);
		logic [3:0] v;
		v = 4'h0;
		for (int d = 0; d < NDIGS; d++) begin
			if (idx == 5'(d)) begin
				v = sig[4*(NDIGS-1-d) +: 4];
			end
		end
		return v;
	endfunction

endpackage

>>> src/qf2h_in_if.sv
interface qf2h_in_if;
	logic valid;
	logic ready;
	logic [63:0] value_high;
	logic [63:0] value_low;
	logic signed [8:0] precision;
	logic upper_case;

	modport source(output valid, value_high, value_low, precision, upper_case, input ready);
	modport sink(input valid, value_high, value_low, precision, upper_case, output ready);
endinterface

>>> src/qf2h_out_if.sv
interface qf2h_out_if;
	logic valid;
	logic ready;
	logic digit_valid;
	logic [4:0] digit_index;
	logic [6:0] digit_char;
	logic is_negative;
	logic is_nan;
	logic is_infinite;
	logic signed [15:0] exponent_out;
	logic [4:0] digits_after_point;
	logic last;

	modport source(output valid, digit_valid, digit_index, digit_char, is_negative, is_nan,
		is_infinite, exponent_out, digits_after_point, last, input ready);
	modport sink(input valid, digit_valid, digit_index, digit_char, is_negative, is_nan,
		is_infinite, exponent_out, digits_after_point, last, output ready);
endinterface

>>> src/qf2h_front.sv
module qf2h_front (
	input  logic clk,
	input  logic arst_n,
	qf2h_in_if.sink request,
	output logic push_valid,
	input  logic push_ready,
	output qf2h_pkg::desc_t push_data
);
	import qf2h_pkg::*;

	logic v_s1;
	front_t f_s1;
	front_t f_d;

	always_comb begin
		logic [14:0] efield;
		logic frac_nz;
		logic [SIG_W-1:0] sig;
		logic [3:0] nib;
		logic [3:0] first;
		logic rest;
		logic lsb;
		logic [4:0] lastnz;
		logic [4:0] prec;
		logic [4:0] full_prec;
		logic [5:0] next_pos;
		efield = request.value_high[62:48];
		frac_nz = (request.value_high[47:0] != 48'd0) || (request.value_low != 64'd0);
		sig = {3'b000, efield != 15'd0, request.value_high[47:0], request.value_low};
		f_d.sig = sig;
		f_d.neg = request.value_high[63];
		f_d.upper = request.upper_case;
		f_d.nan = (efield == EXP_ALL_ONES) && frac_nz;
		f_d.inf = (efield == EXP_ALL_ONES) && !frac_nz;
		if (efield != 15'd0) begin
			f_d.exp = signed'({1'b0, efield}) - EXP_BIAS;
		end else if (frac_nz) begin
			f_d.exp = EXP_DENORM;
		end else begin
			f_d.exp = 16'sd0;
		end
		f_d.round_en = !request.precision[8] && (request.precision[7:0] < PREC_LIMIT);
		if (request.precision[8]) begin
			prec = 5'd0;
		end else if (f_d.round_en) begin
			prec = request.precision[4:0];
		end else begin
			prec = PREC_MAX;
		end
		next_pos = {1'b0, prec} + 6'd1;
		first = 4'h0;
		rest = 1'b0;
		lsb = 1'b0;
		lastnz = 5'd0;
		for (int d = 0; d < NDIGS; d++) begin
			nib = sig[4*(NDIGS-1-d) +: 4];
			if (6'(d) == next_pos) begin
				first = nib;
			end
			if ((6'(d) > next_pos) && (nib != 4'h0)) begin
				rest = 1'b1;
			end
			if (5'(d) == prec) begin
				lsb = nib[0];
			end
			if (nib != 4'h0) begin
				lastnz = 5'(d);
			end
		end
		f_d.up = f_d.round_en && ((first > NIB_HALF) || ((first == NIB_HALF) && (rest || lsb)));
		f_d.prec = prec;
		if (f_d.round_en || (lastnz <= prec)) begin
			full_prec = prec;
		end else begin
			full_prec = lastnz;
		end
		f_d.dap = (efield == EXP_ALL_ONES) ? prec : full_prec;
	end

	assign request.ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (request.ready) begin
			v_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			f_s1 <= f_d;
		end
	end

	always_comb begin
		logic [SIG_W-1:0] keep;
		logic [SIG_W-1:0] inc;
		keep = '0;
		inc = '0;
		for (int d = 0; d < NDIGS; d++) begin
			if (5'(d) <= f_s1.prec) begin
				keep[4*(NDIGS-1-d) +: 4] = 4'hf;
			end
			if ((5'(d) == f_s1.prec) && f_s1.up) begin
				inc[4*(NDIGS-1-d)] = 1'b1;
			end
		end
		push_data.sig = f_s1.round_en ? ((f_s1.sig & keep) + inc) : f_s1.sig;
		push_data.neg = f_s1.neg;
		push_data.nan = f_s1.nan;
		push_data.inf = f_s1.inf;
		push_data.upper = f_s1.upper;
		push_data.exp = f_s1.exp;
		push_data.dap = f_s1.dap;
	end

	assign push_valid = v_s1;

endmodule

>>> src/qf2h_queue.sv
module qf2h_queue #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  qf2h_pkg::desc_t push_data,
	output logic head_valid,
	input  logic pop,
	output qf2h_pkg::desc_t head_data
);
	import qf2h_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	desc_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && head_valid;
	assign head_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> src/qf2h_back.sv
module qf2h_back (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  qf2h_pkg::desc_t head_data,
	output logic pop,
	qf2h_out_if.source result
);
	import qf2h_pkg::*;

	logic out_v_q;
	logic [4:0] idx_q;
	logic load;
	logic special;
	logic last_now;
	logic [3:0] nib;
	logic [6:0] ch;

	assign load = !out_v_q || result.ready;
	assign special = head_data.nan || head_data.inf;
	assign last_now = special || (idx_q == head_data.dap);
	assign pop = load && head_valid && last_now;
	assign nib = nibble_at(head_data.sig, idx_q);

	always_comb begin
		if (nib <= NIB_NINE) begin
			ch = CHAR_ZERO + 7'(nib);
		end else if (head_data.upper) begin
			ch = CHAR_UPPER_BASE + 7'(nib);
		end else begin
			ch = CHAR_LOWER_BASE + 7'(nib);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q <= 5'd0;
		end else if (load) begin
			out_v_q <= head_valid;
			if (head_valid) begin
				idx_q <= last_now ? 5'd0 : idx_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			result.digit_valid <= !special;
			result.digit_index <= special ? 5'd0 : idx_q;
			result.digit_char <= special ? 7'd0 : ch;
			result.is_negative <= head_data.neg;
			result.is_nan <= head_data.nan;
			result.is_infinite <= head_data.inf;
			result.exponent_out <= special ? EXP_SPECIAL : head_data.exp;
			result.digits_after_point <= head_data.dap;
			result.last <= last_now;
		end
	end

	assign result.valid = out_v_q;

endmodule

>>> src/quad_float_to_hex_digits.sv
// Channel   Direction  Payload
// request   in         value_high, value_low, precision, upper_case
// result    out        one hex digit with sign, class, exponent and count flags
//
// Each request yields one to 29 result transactions, one per cycle while result.ready is
// held high; the digit sequencer in the back end emits them, and NaN or infinity gives one.
// A request passes the front-end stage register, a queue entry and the output register.
// Reset is asynchronous and clears the valid flags, the queue count and the digit counter.
// A stalled result holds in the output register; the front end keeps accepting until the
// queue and its own stage register are both full.
module quad_float_to_hex_digits #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	qf2h_in_if.sink request,
	qf2h_out_if.source result
);
	import qf2h_pkg::*;

	logic push_valid;
	logic push_ready;
	desc_t push_data;
	logic head_valid;
	logic pop;
	desc_t head_data;

	qf2h_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.request(request),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	qf2h_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.head_valid(head_valid),
		.pop(pop),
		.head_data(head_data)
	);

	qf2h_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_data(head_data),
		.pop(pop),
		.result(result)
	);

	a_special_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.digit_valid) |-> result.last)
		else $error("special value result is not the last transaction");

	a_last_at_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.digit_valid) |->
		((result.digit_index == result.digits_after_point) == result.last))
		else $error("last flag does not match the final digit position");

	a_digit_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && !result.last) |=>
		(result.valid && (result.digit_index == 5'($past(result.digit_index) + 5'd1))))
		else $error("next digit of the same value did not follow at once");

endmodule

>>> sim/quad_float_to_hex_digits_tb.sv
module quad_float_to_hex_digits_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 12;
	localparam longint CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 10;
	localparam int MAX_REPORTS = 40;
	localparam int GAP_MAX = 19;
	localparam int HOLD_OFF_CYCLES = 400;

	localparam int ALL_FRAC_DIGITS = 28;
	localparam int EXP_OFFSET = 16383;
	localparam bit [14:0] EXP_SPECIAL_FIELD = 15'h7fff;
	localparam bit [14:0] EXP_TOP_NORMAL = 15'h7ffe;
	localparam bit [14:0] EXP_ONE = 15'h3fff;
	localparam bit signed [15:0] DENORM_EXP = -16'sd16382;
	localparam bit signed [15:0] SPECIAL_EXP = 16'sd16384;
	localparam bit [6:0] ASCII_ZERO = 7'h30;
	localparam bit [6:0] ASCII_UPPER_A = 7'h41;
	localparam bit [6:0] ASCII_LOWER_A = 7'h61;
	localparam bit [8:0] PREC_EXACT = 9'h1ff;
	localparam bit [8:0] PREC_MOST_NEGATIVE = 9'h100;
	localparam bit [8:0] PREC_FULL = 9'd28;
	localparam bit [8:0] PREC_TOP = 9'd255;
	localparam bit [63:0] ONES_64 = 64'hffff_ffff_ffff_ffff;
	localparam bit [47:0] ONES_48 = 48'hffff_ffff_ffff;

	typedef struct packed {
		logic digit_valid;
		logic [4:0] index;
		logic [6:0] code;
		logic negative;
		logic nan;
		logic infinite;
		logic signed [15:0] exponent;
		logic [4:0] after_point;
		logic last;
	} hex_digit_t;

	logic clk = 1'b0;
	logic arst_n;

	qf2h_in_if request_ch ();
	qf2h_out_if result_ch ();

	quad_float_to_hex_digits dut (
		.clk(clk),
		.arst_n(arst_n),
		.request(request_ch),
		.result(result_ch)
	);

	hex_digit_t pending_digits[$];

	int source_gap_max = GAP_MAX;
	int sink_stall_max = GAP_MAX;
	int sink_hold_cycles = 0;
	int mismatch_count = 0;
	int values_sent = 0;
	int specials_sent = 0;
	int rounded_up = 0;
	int digits_checked = 0;
	longint cycle_count = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digits still expected", cycle_count,
				pending_digits.size());
			$display("quad_float_to_hex_digits_tb: done, errors");
			$finish;
		end
	end

	function automatic void predict_hex_digits(input bit [63:0] hi, input bit [63:0] lo,
			input bit [8:0] prec_raw, input bit upper);
		bit [115:0] sig;
		bit [115:0] unit;
		bit [115:0] dropped;
		bit [14:0] efield;
		bit frac_nz;
		bit signed [15:0] unb_exp;
		int keep;
		int shift;
		int last_pos;
		bit [3:0] nib;
		hex_digit_t d;
		efield = hi[62:48];
		frac_nz = (hi[47:0] != 48'h0) || (lo != 64'h0);
		sig = {3'b000, efield != 15'h0, hi[47:0], lo};
		if (efield != 15'h0) begin
			unb_exp = 16'(int'(efield) - EXP_OFFSET);
		end else if (frac_nz) begin
			unb_exp = DENORM_EXP;
		end else begin
			unb_exp = 16'sd0;
		end
		if (prec_raw[8]) begin
			keep = 0;
		end else if (prec_raw >= PREC_FULL) begin
			keep = ALL_FRAC_DIGITS;
		end else begin
			keep = prec_raw;
			shift = 4 * (ALL_FRAC_DIGITS - keep);
			unit = 116'b1 << shift;
			dropped = sig & (unit - 116'b1);
			sig = sig - dropped;
			if (dropped > (unit >> 1) || (dropped == (unit >> 1) && sig[shift])) begin
				sig = sig + unit;
				rounded_up++;
			end
		end
		d = '0;
		d.negative = hi[63];
		if (efield == EXP_SPECIAL_FIELD) begin
			d.nan = frac_nz;
			d.infinite = !frac_nz;
			d.exponent = SPECIAL_EXP;
			d.after_point = 5'(keep);
			d.last = 1'b1;
			pending_digits.push_back(d);
			specials_sent++;
			return;
		end
		last_pos = keep;
		for (int p = ALL_FRAC_DIGITS; p > keep; p--) begin
			if (sig[4 * (ALL_FRAC_DIGITS - p) +: 4] != 4'h0) begin
				last_pos = p;
				break;
			end
		end
		d.digit_valid = 1'b1;
		d.exponent = unb_exp;
		d.after_point = 5'(last_pos);
		for (int p = 0; p <= last_pos; p++) begin
			nib = sig[4 * (ALL_FRAC_DIGITS - p) +: 4];
			d.index = 5'(p);
			d.code = (nib <= 4'd9) ? ASCII_ZERO + nib
				: (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + nib - 7'd10;
			d.last = (p == last_pos);
			pending_digits.push_back(d);
		end
	endfunction

	function automatic void check_digit(input hex_digit_t want, input hex_digit_t got);
		string names[9];
		integer w[9];
		integer g[9];
		names = '{"digit_valid", "digit_index", "digit_char", "is_negative", "is_nan",
			"is_infinite", "exponent_out", "digits_after_point", "last"};
		w = '{want.digit_valid, want.index, want.code, want.negative, want.nan,
			want.infinite, want.exponent, want.after_point, want.last};
		g = '{got.digit_valid, got.index, got.code, got.negative, got.nan,
			got.infinite, got.exponent, got.after_point, got.last};
		for (int i = 0; i < 9; i++) begin
			if (g[i] !== w[i]) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("%0t: %s expected %0d, got %0d", $time, names[i], w[i], g[i]);
				end
			end
		end
	endfunction

	always @(posedge clk) begin : digit_checker
		hex_digit_t got;
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got.digit_valid = result_ch.digit_valid;
			got.index = result_ch.digit_index;
			got.code = result_ch.digit_char;
			got.negative = result_ch.is_negative;
			got.nan = result_ch.is_nan;
			got.infinite = result_ch.is_infinite;
			got.exponent = result_ch.exponent_out;
			got.after_point = result_ch.digits_after_point;
			got.last = result_ch.last;
			if (pending_digits.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("%0t: digit expected none, got index %0d char %0d", $time,
						got.index, got.code);
				end
			end else begin
				check_digit(pending_digits.pop_front(), got);
				digits_checked++;
			end
		end
	end

	initial begin : result_sink
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = (sink_stall_max > 0) ? $urandom_range(sink_stall_max, 0) : 0;
			if (sink_hold_cycles > 0) begin
				stall = sink_hold_cycles;
				sink_hold_cycles = 0;
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
		end
	end

	task automatic send_value(input bit [63:0] hi, input bit [63:0] lo, input bit [8:0] prec,
			input bit upper);
		int gap;
		gap = (source_gap_max > 0) ? $urandom_range(source_gap_max, 0) : 0;
		if (gap > 0) begin
			request_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_ch.valid <= 1'b1;
		request_ch.value_high <= hi;
		request_ch.value_low <= lo;
		request_ch.precision <= prec;
		request_ch.upper_case <= upper;
		do @(posedge clk); while (request_ch.ready !== 1'b1);
		predict_hex_digits(hi, lo, prec, upper);
		values_sent++;
	endtask

	task automatic drain_results();
		request_ch.valid <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void draw_value(output bit [63:0] hi, output bit [63:0] lo,
			output bit [8:0] prec, output bit upper);
		bit [111:0] frac;
		bit [14:0] efield;
		int sel;
		int n;
		frac = 112'({$urandom, $urandom, $urandom, $urandom});
		sel = $urandom_range(19, 0);
		if (sel < 2) begin
			efield = 15'h0;
		end else if (sel < 4) begin
			efield = EXP_SPECIAL_FIELD;
		end else if (sel < 6) begin
			efield = $urandom_range(1, 0) ? 15'h1 : EXP_TOP_NORMAL;
		end else begin
			efield = 15'($urandom);
		end
		if ($urandom_range(2, 0) == 0) begin
			n = $urandom_range(ALL_FRAC_DIGITS, 0);
			frac = frac & ~((112'b1 << (4 * (ALL_FRAC_DIGITS - n))) - 112'b1);
		end
		sel = $urandom_range(9, 0);
		if (sel < 2) begin
			prec = 9'($urandom);
		end else if (sel == 2) begin
			prec = PREC_EXACT;
		end else begin
			prec = 9'($urandom_range(ALL_FRAC_DIGITS, 0));
		end
		if (prec < PREC_FULL && $urandom_range(3, 0) == 0) begin
			frac[4 * (27 - prec) +: 4] = 4'h8;
			frac = frac & ~((112'b1 << (4 * (27 - prec))) - 112'b1);
			if ($urandom_range(1, 0) == 1) begin
				frac[0] = 1'b1;
			end
		end
		hi = {1'($urandom), efield, frac[111:64]};
		lo = frac[63:0];
		upper = 1'($urandom);
	endfunction

	task automatic send_random(input int count);
		bit [63:0] hi;
		bit [63:0] lo;
		bit [8:0] prec;
		bit upper;
		repeat (count) begin
			draw_value(hi, lo, prec, upper);
			send_value(hi, lo, prec, upper);
		end
	endtask

	task automatic test_directed();
		send_value({1'b0, 15'h0, 48'h0}, 64'h0, PREC_EXACT, 1'b0);
		send_value({1'b1, 15'h0, 48'h0}, 64'h0, 9'd5, 1'b1);
		send_value({1'b0, EXP_ONE, 48'h0}, 64'h0, PREC_EXACT, 1'b0);
		send_value({1'b0, EXP_TOP_NORMAL, ONES_48}, ONES_64, PREC_EXACT, 1'b1);
		send_value({1'b0, EXP_TOP_NORMAL, ONES_48}, ONES_64, 9'd0, 1'b0);
		send_value({1'b0, EXP_TOP_NORMAL, ONES_48}, ONES_64, 9'd27, 1'b0);
		send_value({1'b1, EXP_TOP_NORMAL, ONES_48}, ONES_64, PREC_FULL, 1'b0);
		send_value({1'b0, 15'h0, 48'h0}, 64'h1, PREC_EXACT, 1'b0);
		send_value({1'b0, 15'h0, 48'h0}, 64'h1, 9'd3, 1'b0);
		send_value({1'b0, 15'h0, ONES_48}, ONES_64, 9'd10, 1'b1);
		send_value({1'b0, EXP_SPECIAL_FIELD, 48'h0}, 64'h0, 9'd4, 1'b0);
		send_value({1'b1, EXP_SPECIAL_FIELD, 48'h0}, 64'h0, PREC_EXACT, 1'b0);
		send_value({1'b0, EXP_SPECIAL_FIELD, 48'h8000_0000_0000}, 64'h0, 9'd200, 1'b0);
		send_value({1'b1, EXP_SPECIAL_FIELD, 48'h0}, 64'h1, PREC_MOST_NEGATIVE, 1'b1);
		send_value({1'b0, EXP_ONE, 48'h1800_0000_0000}, 64'h0, 9'd1, 1'b0);
		send_value({1'b0, EXP_ONE, 48'h2800_0000_0000}, 64'h0, 9'd1, 1'b0);
		send_value({1'b0, EXP_ONE, 48'h2800_0000_0000}, 64'h1, 9'd1, 1'b0);
		send_value({1'b0, EXP_ONE, 48'h27ff_ffff_ffff}, ONES_64, 9'd1, 1'b0);
		send_value({1'b0, EXP_ONE, 48'h8000_0000_0000}, 64'h0, 9'd0, 1'b0);
		send_value({1'b0, 15'h0, 48'h8000_0000_0000}, 64'h0, 9'd0, 1'b0);
		send_value({1'b0, 15'h4000, 48'h0123_4567_89ab}, 64'hcdef_0123_4567_89ab,
			PREC_EXACT, 1'b1);
		send_value({1'b1, 15'h4000, 48'h0123_4567_89ab}, 64'hcdef_0123_4567_89ab,
			PREC_TOP, 1'b0);
		send_value({1'b0, 15'h1, 48'h0}, 64'h0, PREC_FULL, 1'b0);
		send_value({1'b1, EXP_ONE, 48'habc0_0000_0000}, 64'h0, 9'd29, 1'b1);
		drain_results();
	endtask

	task automatic test_random_mix();
		source_gap_max = GAP_MAX;
		sink_stall_max = GAP_MAX;
		send_random(80);
		drain_results();
	endtask

	task automatic test_back_to_back();
		source_gap_max = 0;
		sink_stall_max = 0;
		send_random(20);
		drain_results();
		source_gap_max = GAP_MAX;
		sink_stall_max = GAP_MAX;
	endtask

	task automatic test_output_hold_off();
		source_gap_max = 0;
		sink_hold_cycles = HOLD_OFF_CYCLES;
		send_random(12);
		source_gap_max = GAP_MAX;
		drain_results();
	endtask

	task automatic test_input_pause();
		send_random(12);
		drain_results();
		send_random(12);
		drain_results();
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		request_ch.valid <= 1'b0;
		request_ch.value_high <= 64'h0;
		request_ch.value_low <= 64'h0;
		request_ch.precision <= 9'h0;
		request_ch.upper_case <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix();
		test_back_to_back();
		test_output_hold_off();
		test_input_pause();
		$display({"summary: %0d values converted, %0d NaN or infinity, ",
			"%0d rounded up, %0d digits compared"},
			values_sent, specials_sent, rounded_up, digits_checked);
		$display("summary: extremes, ties, random mix, back-to-back, output hold-off, input pause");
		if (mismatch_count == 0) begin
			$display("quad_float_to_hex_digits_tb: done, clean");
		end else begin
			$display("quad_float_to_hex_digits_tb: done, errors");
		end
		$finish;
	end

endmodule
